[rtl/grmc_pkg.sv]
// Shared constants, types and state codes for the grid ray march column block.
package grmc_pkg;

  // Map store geometry; MAP_DIM is a power of two
  localparam int MAP_DIM   = 32;
  localparam int MAP_CW    = $clog2(MAP_DIM);
  localparam int MAP_AW    = 2 * MAP_CW;
  localparam int MAP_CELLS = MAP_DIM * MAP_DIM;
  localparam logic [6:0] MAP_DIM_W = 7'(MAP_DIM);

  // Angle quantization of the sine lookup; SINE_TABLE_SIZE is a power of two
  localparam int SINE_TABLE_SIZE = 1024;
  localparam int SINE_BITS       = $clog2(SINE_TABLE_SIZE);
  localparam logic [15:0] PHASE_MASK = 16'(16'hFFFF << (16 - SINE_BITS));
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  // Quarter-wave sine polynomial coefficients (Q16)
  localparam logic [16:0] POLY_A = 17'd102944;
  localparam logic [16:0] POLY_B = 17'd42334;
  localparam logic [16:0] POLY_C = 17'd5223;
  localparam logic [16:0] POLY_D = 17'd307;
  localparam logic [16:0] SINE_ONE = 17'd65536;

  // March constants
  localparam logic [16:0] STEP_Q16  = 17'd3277;
  localparam logic [19:0] DIST_CAP  = 20'd655360;
  localparam logic [10:0] MAX_STEPS = 11'd2047;

  // Shared divider geometry
  localparam int DIV_NW = 28;
  localparam int DIV_DW = 20;
  localparam int DIV_CW = $clog2(DIV_NW);

  // Operation codes carried in tuser
  localparam logic OP_WRITE_CELL = 1'b0;
  localparam logic OP_CAST       = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PLAYER_X   = 3'd0,
    CFG_PLAYER_Y   = 3'd1,
    CFG_HEADING    = 3'd2,
    CFG_FOV        = 3'd3,
    CFG_COLUMNS    = 3'd4,
    CFG_ROWS       = 3'd5,
    CFG_MAP_EXTENT = 3'd6
  } cfg_idx_e;

  // Configuration reset values
  localparam logic [20:0] RST_PLAYER_X = 21'd131072;
  localparam logic [20:0] RST_PLAYER_Y = 21'd131072;
  localparam logic [15:0] RST_HEADING  = 16'd0;
  localparam logic [15:0] RST_FOV      = 16'd10923;
  localparam logic [11:0] RST_COLUMNS  = 12'd800;
  localparam logic [11:0] RST_ROWS     = 12'd600;
  localparam logic [5:0]  RST_EXTENT   = 6'd24;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG_MUL,
    ST_ANG_DIV,
    ST_ANG_WAIT,
    ST_SQ,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_P6,
    ST_MARCH,
    ST_DIST,
    ST_DCAP,
    ST_HWAIT,
    ST_OUT
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/grmc_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
module grmc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  grmc_pkg::div_req_t  req_i,
  output grmc_pkg::div_rsp_t  rsp_o
);
  import grmc_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] div_q, div_d;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    rem_sh  = {rem_q, quo_q[DIV_NW-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(DIV_NW - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = rem_sub[DIV_DW-1:0];
        quo_d = {quo_q[DIV_NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_DW-1:0];
        quo_d = {quo_q[DIV_NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[rtl/grid_ray_march_column_top.sv]
// Top level: map store, sequencer, shared multiplier and march datapath.
// A cell write is taken while the sequencer is idle; the block is ready again on the next cycle.
// A cast runs the angle multiply, the cosine and sine polynomials, the march loop, which stops
// at a wall, at the map edge or at the step limit (at most 2047 steps), and the distance multiply,
// with two passes of the shared divider: one for the ray angle, one for the wall height.
// One item is in work at a time; a result waits in the output register.
// Reset (async, active low) restores the configuration defaults and idles the
// sequencer; map cells hold no value until written.
module grid_ray_march_column_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // cell_col[4:0], cell_row[9:5], cell_is_wall[10],
                                      // column_index[21:11], zero[23:22]
  input  logic        s_axis_tuser,   // opcode
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // column_out[10:0], ray_distance[30:11],
                                      // wall_top_row[46:31], wall_bottom_row[62:47],
                                      // hit_wall[63]
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i
);
  import grmc_pkg::*;

  // configuration registers
  logic [20:0] player_x_q, player_y_q;
  logic [15:0] heading_q, fov_q;
  logic [11:0] columns_q, rows_q;
  logic [5:0]  extent_q;

  // sequencer
  state_e state_q, state_d;
  logic   in_acc, out_load;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // datapath
  logic [10:0]        col_q;
  logic [15:0]        phase_q;
  logic [16:0]        x_q, x2_q;
  logic               neg_q, trig_sin_q;
  logic signed [12:0] dx_q, dy_q, d_signed;
  logic signed [24:0] px_q, py_q, px_nx, py_nx;
  logic [10:0]        steps_q;
  logic               pend_q, hit_q;
  logic [19:0]        dist_q, dist_w;
  logic [15:0]        angle_w;
  logic [16:0]        mul_a, mul_b, s_clamp;
  logic [33:0]        prod_q;
  logic [11:0]        d_mag;
  logic [11:0]        cols_eff;

  // march addressing
  logic [6:0]        ext;
  logic              x_oob, y_oob, step_hit, step_end;
  logic [MAP_CW-1:0] cx_addr, cy_addr;
  logic [MAP_AW-1:0] wr_addr;

  // map store
  logic map_q [MAP_CELLS];
  logic mem_rd_q;

  // output register
  logic        m_valid_q;
  logic [63:0] m_data_q;
  logic signed [19:0] top_w, bot_w;
  logic [15:0] half_w;

  function automatic logic [16:0] trig_x(input logic [15:0] p);
    logic [16:0] xr;
    xr = {1'b0, p[13:0], 2'b00};
    return p[14] ? (SINE_ONE - xr) : xr;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [19:0] v);
    if (v < -20'sd32768) return 16'h8000;
    if (v > 20'sd32767)  return 16'h7FFF;
    return v[15:0];
  endfunction

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= RST_PLAYER_X;
      player_y_q <= RST_PLAYER_Y;
      heading_q  <= RST_HEADING;
      fov_q      <= RST_FOV;
      columns_q  <= RST_COLUMNS;
      rows_q     <= RST_ROWS;
      extent_q   <= RST_EXTENT;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PLAYER_X:   player_x_q <= cfg_data_i;
        CFG_PLAYER_Y:   player_y_q <= cfg_data_i;
        CFG_HEADING:    heading_q  <= cfg_data_i[15:0];
        CFG_FOV:        fov_q      <= cfg_data_i[15:0];
        CFG_COLUMNS:    columns_q  <= cfg_data_i[11:0];
        CFG_ROWS:       rows_q     <= cfg_data_i[11:0];
        CFG_MAP_EXTENT: extent_q   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // march step: next position, bounds and map address
  assign ext   = ({1'b0, extent_q} > MAP_DIM_W) ? MAP_DIM_W : {1'b0, extent_q};
  assign px_nx = px_q + {{12{dx_q[12]}}, dx_q};
  assign py_nx = py_q + {{12{dy_q[12]}}, dy_q};

  // a position in (-1, 0) still truncates to cell 0
  assign x_oob = px_nx[24] ? ((px_nx <= -25'sd65536) || (ext == '0))
                           : ({1'b0, px_nx[23:16]} >= {2'b00, ext});
  assign y_oob = py_nx[24] ? ((py_nx <= -25'sd65536) || (ext == '0))
                           : ({1'b0, py_nx[23:16]} >= {2'b00, ext});
  assign cx_addr = px_nx[24] ? '0 : px_nx[16 +: MAP_CW];
  assign cy_addr = py_nx[24] ? '0 : py_nx[16 +: MAP_CW];

  assign step_hit = pend_q && mem_rd_q;
  assign step_end = step_hit || (steps_q == MAX_STEPS) || x_oob || y_oob;

  // map store: write on a cell transaction, read the next march cell every cycle
  assign wr_addr = {MAP_CW'(s_axis_tdata[9:5]), MAP_CW'(s_axis_tdata[4:0])};

  always_ff @(posedge clk_i) begin
    if (in_acc && (s_axis_tuser == OP_WRITE_CELL) &&
        (32'(s_axis_tdata[4:0]) < MAP_DIM) && (32'(s_axis_tdata[9:5]) < MAP_DIM)) begin
      map_q[wr_addr] <= s_axis_tdata[10];
    end
    mem_rd_q <= map_q[{cy_addr, cx_addr}];
  end

  // shared multiplier operands
  assign s_clamp = (prod_q[32:16] > SINE_ONE) ? SINE_ONE : prod_q[32:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_ANG_MUL: begin
        mul_a = {1'b0, fov_q};
        mul_b = {6'b0, col_q};
      end
      ST_SQ: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      ST_P1: begin
        mul_a = prod_q[32:16];
        mul_b = POLY_D;
      end
      ST_P2: begin
        mul_a = x2_q;
        mul_b = POLY_C - prod_q[32:16];
      end
      ST_P3: begin
        mul_a = x2_q;
        mul_b = POLY_B - prod_q[32:16];
      end
      ST_P4: begin
        mul_a = x_q;
        mul_b = POLY_A - prod_q[32:16];
      end
      ST_P5: begin
        mul_a = s_clamp;
        mul_b = STEP_Q16;
      end
      ST_DIST: begin
        mul_a = {6'b0, steps_q};
        mul_b = STEP_Q16;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // divider operands
  assign cols_eff = (columns_q == '0) ? 12'd1 : columns_q;
  assign dist_w   = (prod_q[22:0] > {3'b000, DIST_CAP}) ? DIST_CAP : prod_q[19:0];
  assign angle_w  = heading_q - {1'b0, fov_q[15:1]} + div_rsp.quotient[15:0];
  assign d_mag    = prod_q[27:16];
  assign d_signed = neg_q ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {rows_q, 16'h0000};
    div_req.divisor  = dist_w;
    if (state_q == ST_ANG_DIV) begin
      div_req.start    = 1'b1;
      div_req.dividend = {1'b0, prod_q[26:0]};
      div_req.divisor  = {8'h00, cols_eff};
    end else if (state_q == ST_DCAP) begin
      div_req.start = 1'b1;
    end
  end

  grmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (s_axis_tuser == OP_CAST)) state_d = ST_ANG_MUL;
      end
      ST_ANG_MUL:  state_d = ST_ANG_DIV;
      ST_ANG_DIV:  state_d = ST_ANG_WAIT;
      ST_ANG_WAIT: if (div_rsp.done) state_d = ST_SQ;
      ST_SQ:       state_d = ST_P1;
      ST_P1:       state_d = ST_P2;
      ST_P2:       state_d = ST_P3;
      ST_P3:       state_d = ST_P4;
      ST_P4:       state_d = ST_P5;
      ST_P5:       state_d = ST_P6;
      ST_P6:       state_d = trig_sin_q ? ST_MARCH : ST_SQ;
      ST_MARCH: begin
        if (step_end) state_d = ST_DIST;
      end
      ST_DIST:  state_d = ST_DCAP;
      ST_DCAP:  state_d = ST_HWAIT;
      ST_HWAIT: if (div_rsp.done) state_d = ST_OUT;
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)           m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // result rows, centered on half the screen height
  assign half_w = div_rsp.quotient[16:1];
  assign top_w  = $signed({9'b0, rows_q[11:1]}) - $signed({4'b0, half_w});
  assign bot_w  = $signed({9'b0, rows_q[11:1]}) + $signed({4'b0, half_w});

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) col_q <= s_axis_tdata[21:11];

    if ((state_q == ST_ANG_WAIT) && div_rsp.done) begin
      // start with cosine, its phase a quarter turn ahead of the sine phase
      phase_q    <= angle_w & PHASE_MASK;
      x_q        <= trig_x((angle_w & PHASE_MASK) + QUARTER_TURN);
      neg_q      <= ((angle_w & PHASE_MASK) + QUARTER_TURN) >= 16'h8000;
      trig_sin_q <= 1'b0;
    end

    if (state_q == ST_P1) x2_q <= prod_q[32:16];

    if (state_q == ST_P6) begin
      if (!trig_sin_q) begin
        dx_q       <= d_signed;
        x_q        <= trig_x(phase_q);
        neg_q      <= phase_q[15];
        trig_sin_q <= 1'b1;
      end else begin
        dy_q    <= d_signed;
        px_q    <= {4'b0, player_x_q};
        py_q    <= {4'b0, player_y_q};
        steps_q <= '0;
        pend_q  <= 1'b0;
      end
    end

    if (state_q == ST_MARCH) begin
      hit_q <= step_hit;
      // advance unless the previous cell was a wall or the step limit is reached
      if (!step_hit && (steps_q != MAX_STEPS)) begin
        px_q    <= px_nx;
        py_q    <= py_nx;
        steps_q <= steps_q + 1'b1;
        pend_q  <= 1'b1;
      end
    end

    if (state_q == ST_DCAP) dist_q <= dist_w;

    // load only when the output register is free; the quotient holds until then
    if (out_load) begin
      m_data_q[10:0]  <= col_q;
      m_data_q[30:11] <= dist_q;
      m_data_q[46:31] <= sat16(top_w);
      m_data_q[62:47] <= sat16(bot_w);
      m_data_q[63]    <= hit_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[test/testbench.sv]
// Self-checking testbench for grid_ray_march_column_top: map cell writes and column casts.
module testbench;
  import grmc_pkg::*;

  localparam int         LIMIT_CYCLES  = 10_000_000;
  localparam int         SETTLE_CYCLES = 100;
  localparam int         HOLD_CYCLES   = 3000;
  localparam int         PHASES        = 3;
  localparam int         PHASE_ITEMS   = 80;
  localparam int         LOAD_DIM      = 24;
  localparam logic [2:0] CFG_SPARE     = 3'd7;
  localparam longint     STEP_LEN      = 3277;
  localparam longint     DIST_LIMIT    = 655360;
  localparam longint     STEP_LIMIT    = 2047;

  // Same layout as m_axis_tdata, lowest field last
  typedef struct packed {
    logic        hit;
    logic [15:0] bottom;
    logic [15:0] top;
    logic [19:0] distance;
    logic [10:0] col;
  } column_t;

  // Raw register words, upper bits beyond each register width included
  typedef struct {
    logic [20:0] px, py, heading, fov, cols, rows, extent;
  } view_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [20:0] cfg_data_i = '0;

  // Predicted block state
  logic [20:0] view_x = RST_PLAYER_X;
  logic [20:0] view_y = RST_PLAYER_Y;
  logic [15:0] view_heading = RST_HEADING;
  logic [15:0] view_fov = RST_FOV;
  logic [11:0] view_cols = RST_COLUMNS;
  logic [11:0] view_rows = RST_ROWS;
  logic [5:0]  view_extent = RST_EXTENT;
  bit          map_wall [MAP_DIM][MAP_DIM];  // [row][col]
  column_t     expected_columns [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  bit steady_flow = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  grid_ray_march_column_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Quarter-wave polynomial sine, Q16, phase in turn units
  function automatic longint sine_q16(input logic [15:0] phase);
    longint x, x2, r, s;
    x = {phase[13:0], 2'b00};
    if (phase[14]) x = 65536 - x;
    x2 = (x * x) >> 16;
    r = 307;
    r = 5223 - ((x2 * r) >> 16);
    r = 42334 - ((x2 * r) >> 16);
    r = 102944 - ((x2 * r) >> 16);
    s = (x * r) >> 16;
    if (s > 65536) s = 65536;
    return phase[15] ? -s : s;
  endfunction

  function automatic longint per_step(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m * STEP_LEN) >> 16;
    return (v < 0) ? -m : m;
  endfunction

  // Truncate toward zero
  function automatic longint cell_index(input longint p);
    return (p < 0) ? -((-p) >> 16) : (p >> 16);
  endfunction

  function automatic logic [15:0] clamp_row(input longint v);
    if (v < -32768) return 16'h8000;
    if (v > 32767) return 16'h7FFF;
    return 16'(v);
  endfunction

  function automatic column_t march_column(input logic [10:0] col);
    column_t res;
    longint ncols, fov_l, col_l, angle, idx, phase, dx, dy, ext;
    longint px, py, cx, cy, steps, ray_len, height, half;
    bit hit, stop;
    ncols = (view_cols == 0) ? 1 : view_cols;
    fov_l = view_fov;
    col_l = col;
    angle = view_heading;
    angle = angle - (fov_l >> 1) + (fov_l * col_l) / ncols;
    angle = angle & 64'hFFFF;
    idx   = (angle * SINE_TABLE_SIZE) >> 16;
    phase = ((idx * 65536) / SINE_TABLE_SIZE) & 64'hFFFF;
    dx = per_step(sine_q16(16'(phase + 16384)));
    dy = per_step(sine_q16(16'(phase)));
    ext = (view_extent > MAP_DIM) ? MAP_DIM : view_extent;
    px = view_x;
    py = view_y;
    steps = 0;
    hit = 1'b0;
    stop = 1'b0;
    while (!stop && steps < STEP_LIMIT) begin
      px += dx;
      py += dy;
      steps++;
      cx = cell_index(px);
      cy = cell_index(py);
      if (cx < 0 || cy < 0 || cx >= ext || cy >= ext) begin
        stop = 1'b1;
      end else if (map_wall[cy][cx]) begin
        hit = 1'b1;
        stop = 1'b1;
      end
    end
    ray_len = steps * STEP_LEN;
    if (ray_len > DIST_LIMIT) ray_len = DIST_LIMIT;
    height = (longint'(view_rows) << 16) / ray_len;
    half = height >> 1;
    res.col      = col;
    res.distance = 20'(ray_len);
    res.top      = clamp_row(longint'(view_rows >> 1) - half);
    res.bottom   = clamp_row(longint'(view_rows >> 1) + half);
    res.hit      = hit;
    return res;
  endfunction

  function automatic void load_reg(input logic [2:0] idx, input logic [20:0] val);
    case (idx)
      CFG_PLAYER_X:   view_x = val;
      CFG_PLAYER_Y:   view_y = val;
      CFG_HEADING:    view_heading = val[15:0];
      CFG_FOV:        view_fov = val[15:0];
      CFG_COLUMNS:    view_cols = val[11:0];
      CFG_ROWS:       view_rows = val[11:0];
      CFG_MAP_EXTENT: view_extent = val[5:0];
      default: ;
    endcase
  endfunction

  // Track accepted register writes and items
  always @(posedge clk_i) begin : track_inputs
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) load_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_WRITE_CELL)
          map_wall[s_axis_tdata[9:5]][s_axis_tdata[4:0]] = s_axis_tdata[10];
        else
          expected_columns.push_back(march_column(s_axis_tdata[21:11]));
      end
    end
  end

  always @(posedge clk_i) begin : check_columns
    column_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_columns.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result transaction: %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_columns.pop_front();
        if (got.col !== want.col || got.distance !== want.distance || got.top !== want.top ||
            got.bottom !== want.bottom || got.hit !== want.hit) begin
          if (mismatch_count < 10)
            $display("mismatch: expected col %0d dist %0d top %0d bottom %0d hit %0b,",
                     want.col, want.distance, $signed(want.top), $signed(want.bottom),
                     want.hit,
                     " got col %0d dist %0d top %0d bottom %0d hit %0b",
                     got.col, got.distance, $signed(got.top), $signed(got.bottom), got.hit);
          mismatch_count++;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin : drive_ready
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady_flow || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [23:0] item_word(input logic [4:0] c, input logic [4:0] r,
                                            input logic w, input logic [10:0] ci);
    return {2'b00, ci, w, r, c};
  endfunction

  function automatic view_t make_view(input logic [20:0] px, py, heading, fov, cols, rows,
                                      extent);
    view_t v;
    v.px = px;
    v.py = py;
    v.heading = heading;
    v.fov = fov;
    v.cols = cols;
    v.rows = rows;
    v.extent = extent;
    return v;
  endfunction

  // Extent stays within the loaded part of the map
  function automatic view_t random_view();
    view_t v;
    int span;
    v.extent = ($urandom_range(9) == 0) ? {15'($urandom), 6'($urandom_range(LOAD_DIM, 0))}
                                        : 21'($urandom_range(LOAD_DIM, 4));
    span = (v.extent[5:0] == 0) ? LOAD_DIM : v.extent[5:0];
    v.px = ($urandom_range(9) == 0) ? 21'($urandom) : 21'($urandom_range(span * 65536 - 1, 0));
    v.py = ($urandom_range(9) == 0) ? 21'($urandom) : 21'($urandom_range(span * 65536 - 1, 0));
    v.heading = 21'($urandom);
    v.fov  = ($urandom_range(9) == 0) ? 21'($urandom) : 21'($urandom_range(32768, 1));
    v.cols = ($urandom_range(9) == 0) ? 21'($urandom) : 21'($urandom_range(2048, 1));
    v.rows = ($urandom_range(9) == 0) ? 21'($urandom) : 21'($urandom_range(2048, 1));
    return v;
  endfunction

  // Hold valid high across back-to-back items; drop it only for a gap
  task automatic send_item(input logic op, input logic [23:0] word);
    int gap;
    if (!steady_flow && $urandom_range(99) < 25) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(200, 1) : $urandom_range(6, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_cell(input logic [4:0] c, input logic [4:0] r, input logic w);
    send_item(OP_WRITE_CELL, item_word(c, r, w, 11'($urandom)));
  endtask

  task automatic cast_column(input logic [10:0] col);
    send_item(OP_CAST, item_word(5'($urandom), 5'($urandom), 1'($urandom), col));
  endtask

  // Drain all casts, then let a trailing cell write finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_columns.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [20:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic apply_view(input view_t v);
    wait_idle();
    put_reg(CFG_PLAYER_X, v.px);
    put_reg(CFG_PLAYER_Y, v.py);
    put_reg(CFG_HEADING, v.heading);
    put_reg(CFG_FOV, v.fov);
    put_reg(CFG_COLUMNS, v.cols);
    put_reg(CFG_ROWS, v.rows);
    put_reg(CFG_MAP_EXTENT, v.extent);
    cfg_valid_i <= 1'b0;
  endtask

  // Load the square that every later cast stays inside
  task automatic test_map_load();
    logic wall;
    for (int r = 0; r < LOAD_DIM; r++) begin
      for (int c = 0; c < LOAD_DIM; c++) begin
        // keep rows 0 to 3 open as a corridor, with one wall block in row 2
        if (r < 4) wall = (r == 2 && c == 16);
        else wall = ($urandom_range(99) < 15);
        write_cell(5'(c), 5'(r), wall);
      end
    end
  endtask

  task automatic test_reset_view();
    cast_column(11'd0);
    cast_column(11'd799);
    cast_column(11'd2047);
  endtask

  task automatic test_view_extremes();
    // long empty corridor: distance caps, ray leaves the map
    apply_view(make_view(21'd163840, 21'd98304, 21'd0, 21'd1, 21'd1, 21'd600, 21'd24));
    cast_column(11'd0);
    write_cell(5'd20, 5'd1, 1'b1);
    cast_column(11'd0);
    write_cell(5'd20, 5'd1, 1'b0);
    cast_column(11'd2047);
    // heading west from x 0.3: ray crosses negative x inside cell 0, zero columns
    apply_view(make_view(21'd19661, 21'd98304, 21'd32768, 21'd1, 21'd0, 21'd0, 21'd63));
    cast_column(11'd0);
    cast_column(11'd1);
    cast_column(11'd2047);
    // wall one step ahead with tall screen: rows saturate
    apply_view(make_view(21'd1047265, 21'd163840, 21'd0, 21'd32768, 21'd2048, 21'd4095,
                         21'd24));
    cast_column(11'd1024);
    cast_column(11'd0);
    cast_column(11'd2047);
    // zero extent: every ray leaves at its first step
    apply_view(make_view(21'd2097151, 21'd0, 21'd65535, 21'd32768, 21'd1, 21'd1, 21'd0));
    cast_column(11'd0);
    cast_column(11'd2047);
    apply_view(make_view(21'd0, 21'd2097151, 21'd16384, 21'd65535, 21'd4095, 21'd2048,
                         21'd24));
    cast_column(11'd0);
    cast_column(11'd2047);
    // unused register index must leave the view alone
    wait_idle();
    put_reg(CFG_SPARE, 21'($urandom));
    cfg_valid_i <= 1'b0;
    cast_column(11'd5);
  endtask

  task automatic test_output_backpressure();
    apply_view(random_view());
    hold_req++;
    for (int n = 0; n < 12; n++) cast_column(11'($urandom_range(2047, 0)));
    wait_idle();
  endtask

  task automatic test_random_phases();
    logic [10:0] col;
    int top_col;
    for (int ph = 0; ph < PHASES; ph++) begin
      apply_view(random_view());
      steady_flow = (ph == 1);
      top_col = (view_cols == 0) ? 0 : view_cols - 1;
      if (top_col > 2047) top_col = 2047;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 20) begin
          write_cell(5'($urandom), 5'($urandom), $urandom_range(99) < 15);
        end else begin
          if ($urandom_range(4) == 0) col = 11'($urandom);
          else col = 11'($urandom_range(top_col, 0));
          cast_column(col);
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_map_load();
    test_reset_view();
    test_view_extremes();
    test_output_backpressure();
    test_random_phases();
    wait_idle();
    if (mismatch_count == 0 && expected_columns.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/grmc_pkg.sv
rtl/grmc_div.sv
rtl/grid_ray_march_column_top.sv
test/testbench.sv
